FILE: rtl/core/fmm_pkg.sv
// fmm_pkg: shared types, constants and binary32 helper functions for the
// 4x4 float matrix multiplier. No dependencies.
package fmm_pkg;

  localparam int DIM    = 4;             // matrix dimension, 2..4
  localparam int NCOL   = 4;             // columns carried by one word
  localparam int CW     = $clog2(DIM);   // cell index width
  localparam int SIGW   = 58;            // working significand width
  localparam int NSTAGE = 6;             // pipeline stages per cell

  // word operations
  localparam logic OP_LOAD = 1'b0;       // load a row of B
  localparam logic OP_MUL  = 1'b1;       // multiply a row of A

  localparam logic [31:0] QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] NEG_ZERO = 32'h8000_0000;

  typedef logic [31:0] word_t;

  // one word travelling down the chain of cells
  typedef struct packed {
    logic                  op;
    logic [1:0]            row;
    word_t [NCOL-1:0]      a;
    word_t [NCOL-1:0]      acc;
  } item_t;

  // unrounded value sig * 2^e, or a finished special value
  typedef struct packed {
    logic                  spec;
    word_t                 sval;
    logic                  sign;
    logic signed [11:0]    e;
    logic [SIGW-1:0]       sig;
    logic signed [9:0]     sh;
  } rp_t;

  typedef struct packed {
    logic [23:0]           m;
    logic signed [11:0]    e;
  } split_t;

  function automatic logic is_nan(word_t x);
    return x[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic is_inf(word_t x);
    return x[30:0] == 31'h7F80_0000;
  endfunction

  function automatic logic is_zero(word_t x);
    return x[30:0] == 31'h0;
  endfunction

  // finite operand to significand and exponent
  function automatic split_t split(word_t x);
    split_t r;
    if (x[30:23] != 8'h0) begin
      r.m = {1'b1, x[22:0]};
      r.e = $signed({4'b0, x[30:23]}) - 12'sd150;
    end else begin
      r.m = {1'b0, x[22:0]};
      r.e = -12'sd149;
    end
    return r;
  endfunction

  // multiply: specials and significand product
  function automatic rp_t mul_front(word_t a, word_t b);
    rp_t    r;
    split_t sa;
    split_t sb;
    logic [47:0] p;
    r      = '0;
    r.sign = a[31] ^ b[31];
    sa     = split(a);
    sb     = split(b);
    p      = sa.m * sb.m;
    if (is_nan(a) || is_nan(b)) begin
      r.spec = 1'b1;
      r.sval = QNAN;
    end else if (is_inf(a) || is_inf(b)) begin
      r.spec = 1'b1;
      r.sval = (is_zero(a) || is_zero(b)) ? QNAN : {r.sign, 31'h7F80_0000};
    end else if (is_zero(a) || is_zero(b)) begin
      r.spec = 1'b1;
      r.sval = {r.sign, 31'h0};
    end else begin
      r.sig = SIGW'(p);
      r.e   = sa.e + sb.e;
    end
    return r;
  endfunction

  // add: specials, alignment with sticky bit, add or subtract
  function automatic rp_t add_front(word_t a, word_t b);
    rp_t    r;
    word_t  x;
    word_t  y;
    split_t sx;
    split_t sy;
    logic signed [11:0] d;
    logic [SIGW-1:0] bx;
    logic [SIGW-1:0] by;
    logic [SIGW-1:0] full;
    r = '0;
    if (a[30:23] >= b[30:23]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    sx   = split(x);
    sy   = split(y);
    d    = sx.e - sy.e;
    bx   = SIGW'(sx.m) << 32;
    full = SIGW'(sy.m) << 32;
    if (d >= 12'sd56) begin
      by = SIGW'(1);
    end else begin
      by = full >> d[5:0];
      if ((full & ((SIGW'(1) << d[5:0]) - SIGW'(1))) != '0) by[0] = 1'b1;
    end
    r.e = sx.e - 12'sd32;
    if (is_nan(a) || is_nan(b)) begin
      r.spec = 1'b1;
      r.sval = QNAN;
    end else if (is_inf(a) && is_inf(b)) begin
      r.spec = 1'b1;
      r.sval = (a[31] == b[31]) ? a : QNAN;
    end else if (is_inf(a)) begin
      r.spec = 1'b1;
      r.sval = a;
    end else if (is_inf(b)) begin
      r.spec = 1'b1;
      r.sval = b;
    end else if (is_zero(a) && is_zero(b)) begin
      r.spec = 1'b1;
      r.sval = {a[31] & b[31], 31'h0};
    end else if (is_zero(a)) begin
      r.spec = 1'b1;
      r.sval = b;
    end else if (is_zero(b)) begin
      r.spec = 1'b1;
      r.sval = a;
    end else if (x[31] == y[31]) begin
      r.sig  = bx + by;
      r.sign = x[31];
    end else if (bx == by) begin
      r.spec = 1'b1;
      r.sval = 32'h0;
    end else if (bx > by) begin
      r.sig  = bx - by;
      r.sign = x[31];
    end else begin
      r.sig  = by - bx;
      r.sign = y[31];
    end
    return r;
  endfunction

  // rounding, first half: leading one and shift amount
  function automatic rp_t rp_prep(rp_t r);
    rp_t o;
    logic signed [12:0] p;
    logic signed [12:0] sh;
    logic signed [12:0] lim;
    o = r;
    p = '0;
    for (int i = 0; i < SIGW; i++) begin
      if (r.sig[i]) p = 13'(i);
    end
    sh  = p - 13'sd23;
    lim = -13'sd149 - 13'(r.e);
    if (lim > sh) sh = lim;
    o.sh = sh[9:0];
    return o;
  endfunction

  // rounding, second half: shift, round to nearest even, pack
  function automatic word_t rp_fin(rp_t r);
    logic [SIGW-1:0]    mask;
    logic [SIGW-1:0]    rem;
    logic [SIGW-1:0]    half;
    logic [24:0]        m;
    logic [5:0]         s6;
    logic signed [12:0] ee;
    logic signed [12:0] be;
    ee   = 13'(r.e) + 13'(r.sh);
    m    = '0;
    s6   = '0;
    mask = '0;
    rem  = '0;
    half = '0;
    if (r.sh > 10'sd58) begin
      m = '0;
    end else if (r.sh > 10'sd0) begin
      s6   = r.sh[5:0];
      m    = 25'(r.sig >> s6);
      mask = (SIGW'(1) << s6) - SIGW'(1);
      rem  = r.sig & mask;
      half = SIGW'(1) << (s6 - 6'd1);
      if (rem > half || (rem == half && m[0])) m = m + 25'd1;
    end else begin
      s6 = 6'(10'sd0 - r.sh);
      m  = 25'(r.sig << s6);
    end
    if (m[24]) begin
      m  = m >> 1;
      ee = ee + 13'sd1;
    end
    be = ee + 13'sd150;
    if (r.spec) return r.sval;
    if (m == '0) return {r.sign, 31'h0};
    if (!m[23]) return {r.sign, 8'h0, m[22:0]};
    if (be >= 13'sd255) return {r.sign, 31'h7F80_0000};
    return {r.sign, be[7:0], m[22:0]};
  endfunction

  // element k of a word, +0 past the carried columns
  function automatic word_t elem_of(word_t [NCOL-1:0] a, logic [CW-1:0] k);
    word_t r;
    r = '0;
    for (int i = 0; i < NCOL; i++) begin
      if (4'(i) == 4'(k)) r = a[i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/fmm_stream_if.sv
// fmm_in_if / fmm_out_if: valid-ready channels of the matrix multiplier.
// No dependencies.
interface fmm_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [1:0]  row_index;
  logic [31:0] elem0;
  logic [31:0] elem1;
  logic [31:0] elem2;
  logic [31:0] elem3;

  modport source (output valid, op, row_index, elem0, elem1, elem2, elem3, input ready);
  modport sink   (input valid, op, row_index, elem0, elem1, elem2, elem3, output ready);
endinterface

interface fmm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_row;
  logic [31:0] prod0;
  logic [31:0] prod1;
  logic [31:0] prod2;
  logic [31:0] prod3;

  modport source (output valid, out_row, prod0, prod1, prod2, prod3, input ready);
  modport sink   (input valid, out_row, prod0, prod1, prod2, prod3, output ready);
endinterface

FILE: rtl/core/fmm_cell.sv
// fmm_cell: one cell of the chain; holds one row of B, multiplies its element
// of the A row by it and adds to the running sums. Depends on fmm_pkg.
module fmm_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [fmm_pkg::CW-1:0]  idx_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  fmm_pkg::item_t          in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output fmm_pkg::item_t          out_item_o
);

  localparam int NS = fmm_pkg::NSTAGE;

  logic [NS-1:0]   v_q;
  logic [NS-1:0]   en;
  fmm_pkg::item_t  it_q [NS];
  fmm_pkg::word_t  brow_q [fmm_pkg::NCOL];
  fmm_pkg::rp_t    m1_q [fmm_pkg::NCOL];
  fmm_pkg::rp_t    m2_q [fmm_pkg::NCOL];
  fmm_pkg::word_t  pr_q [fmm_pkg::NCOL];
  fmm_pkg::rp_t    a1_q [fmm_pkg::NCOL];
  fmm_pkg::rp_t    a2_q [fmm_pkg::NCOL];
  fmm_pkg::item_t  it_fin;
  fmm_pkg::word_t  a_k;
  logic            load_row;

  // a stage takes a new word when empty or when its word moves on
  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int s = NS - 2; s >= 0; s--) en[s] = !v_q[s] || en[s+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign out_item_o  = it_q[NS-1];

  assign a_k      = fmm_pkg::elem_of(in_item_i.a, idx_i);
  assign load_row = en[0] && in_valid_i && (in_item_i.op == fmm_pkg::OP_LOAD) &&
                    (4'(in_item_i.row) == 4'(idx_i));

  // last stage word with the rounded running sums
  always_comb begin
    it_fin = it_q[4];
    for (int j = 0; j < fmm_pkg::NCOL; j++) it_fin.acc[j] = fmm_pkg::rp_fin(a2_q[j]);
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // row store and datapath: mul, round (2), add, round (2)
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < fmm_pkg::NCOL; j++) begin
      if (load_row) brow_q[j] <= in_item_i.a[j];
    end
    if (en[0]) begin
      it_q[0] <= in_item_i;
      for (int j = 0; j < fmm_pkg::NCOL; j++) m1_q[j] <= fmm_pkg::mul_front(a_k, brow_q[j]);
    end
    if (en[1]) begin
      it_q[1] <= it_q[0];
      for (int j = 0; j < fmm_pkg::NCOL; j++) m2_q[j] <= fmm_pkg::rp_prep(m1_q[j]);
    end
    if (en[2]) begin
      it_q[2] <= it_q[1];
      for (int j = 0; j < fmm_pkg::NCOL; j++) pr_q[j] <= fmm_pkg::rp_fin(m2_q[j]);
    end
    if (en[3]) begin
      it_q[3] <= it_q[2];
      for (int j = 0; j < fmm_pkg::NCOL; j++) begin
        a1_q[j] <= fmm_pkg::add_front(pr_q[j], it_q[2].acc[j]);
      end
    end
    if (en[4]) begin
      it_q[4] <= it_q[3];
      for (int j = 0; j < fmm_pkg::NCOL; j++) a2_q[j] <= fmm_pkg::rp_prep(a1_q[j]);
    end
    if (en[5]) begin
      it_q[5] <= it_fin;
    end
  end

endmodule

FILE: rtl/core/float_matrix_multiply_4x4.sv
// float_matrix_multiply_4x4: top level, a chain of DIM cells and an output
// register. Depends on fmm_pkg, fmm_stream_if and fmm_cell.
//
//   channel | dir | word
//   in_i    | in  | op, row_index, elem0..elem3 (load B row / multiply A row)
//   out_o   | out | out_row, prod0..prod3 (one per multiply word)
//
// Each cell has six stages (multiply, two rounding stages, add, two rounding
// stages), and the output register follows the last cell; one word is taken
// every cycle unless the chain stalls. Loads travel down the chain with the
// multiply words, so each cell updates its row of B in order. Reset clears
// valids only; B holds nothing meaningful until loaded. A stalled output lets
// the chain fill its empty stages before input ready drops.
module float_matrix_multiply_4x4 (
  input  logic    clk_i,
  input  logic    rst_ni,
  fmm_in_if.sink  in_i,
  fmm_out_if.source out_o
);

  logic            vld [fmm_pkg::DIM+1];
  logic            rdy [fmm_pkg::DIM+1];
  fmm_pkg::item_t  itm [fmm_pkg::DIM+1];
  logic            ov_q;
  logic [1:0]      row_q;
  fmm_pkg::word_t  prod_q [fmm_pkg::NCOL];
  logic            take;

  // input word into the chain; rows past DIM are dropped
  always_comb begin
    itm[0].op  = in_i.op;
    itm[0].row = in_i.row_index;
    itm[0].a   = {in_i.elem3, in_i.elem2, in_i.elem1, in_i.elem0};
    for (int j = 0; j < fmm_pkg::NCOL; j++) itm[0].acc[j] = fmm_pkg::NEG_ZERO;
  end
  assign vld[0]     = in_i.valid && (4'(in_i.row_index) < 4'(fmm_pkg::DIM));
  assign in_i.ready = rdy[0];

  for (genvar k = 0; k < fmm_pkg::DIM; k++) begin : g_cell
    fmm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (fmm_pkg::CW'(k)),
      .in_valid_i  (vld[k]),
      .in_ready_o  (rdy[k]),
      .in_item_i   (itm[k]),
      .out_valid_o (vld[k+1]),
      .out_ready_i (rdy[k+1]),
      .out_item_o  (itm[k+1])
    );
  end

  // output register; load words leave the chain here
  assign rdy[fmm_pkg::DIM] = !ov_q || out_o.ready;
  assign take = vld[fmm_pkg::DIM] && (itm[fmm_pkg::DIM].op == fmm_pkg::OP_MUL) &&
                rdy[fmm_pkg::DIM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (rdy[fmm_pkg::DIM]) begin
      ov_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      row_q <= itm[fmm_pkg::DIM].row;
      for (int j = 0; j < fmm_pkg::NCOL; j++) begin
        prod_q[j] <= (j < fmm_pkg::DIM) ? itm[fmm_pkg::DIM].acc[j] : '0;
      end
    end
  end

  assign out_o.valid   = ov_q;
  assign out_o.out_row = row_q;
  assign out_o.prod0   = prod_q[0];
  assign out_o.prod1   = prod_q[1];
  assign out_o.prod2   = prod_q[2];
  assign out_o.prod3   = prod_q[3];

endmodule

FILE: rtl/core/fmm_checker.sv
// fmm_checker: port-level assertions for float_matrix_multiply_4x4, bound to
// the top level. No package dependency.
module fmm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_row_i,
  input logic [31:0] prod0_i,
  input logic [31:0] prod1_i,
  input logic [31:0] prod2_i,
  input logic [31:0] prod3_i
);

  // output register empty means the whole chain can move
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("input stalled with empty output");

  // no result shows while in reset
  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i) else $error("output valid during reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result word dropped");

  a_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable({out_row_i, prod0_i, prod1_i, prod2_i, prod3_i}))
    else $error("stalled result word changed");

endmodule

bind float_matrix_multiply_4x4 fmm_checker u_fmm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_row_i   (out_o.out_row),
  .prod0_i     (out_o.prod0),
  .prod1_i     (out_o.prod1),
  .prod2_i     (out_o.prod2),
  .prod3_i     (out_o.prod3)
);
